### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the rigid body integrator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define RBI_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define RBI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define RBI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and constants of the 2D rigid body integrator: beat payloads,
// operation and register codes, and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package rbi_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 31;

   localparam logic [CFG_W-1:0] INV_MASS_RESET    = 31'd65536;
   localparam logic [CFG_W-1:0] INV_INERTIA_RESET = 31'd65536;
   localparam logic [CFG_W-1:0] TIME_STEP_RESET   = 31'd1092;

   // Micro-step counter width (longest program has 13 steps)
   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      CSR_INV_MASS    = 3'd0,
      CSR_INV_INERTIA = 3'd1,
      CSR_TIME_STEP   = 3'd2,
      CSR_MOVE_LOCK   = 3'd3,
      CSR_ROT_LOCK    = 3'd4
   } rbi_csr_type;

   typedef enum logic [2:0] {
      OP_ADD_FORCE     = 3'd0,
      OP_ADD_TORQUE    = 3'd1,
      OP_LIN_IMPULSE   = 3'd2,
      OP_ANG_IMPULSE   = 3'd3,
      OP_POINT_IMPULSE = 3'd4,
      OP_INTEG_FORCE   = 3'd5,
      OP_INTEG_VEL     = 3'd6
   } rbi_op_type;

   // Multiplier operand A sources
   typedef enum logic [3:0] {
      A_JX, A_JY, A_S, A_RX, A_RY, A_T, A_FX, A_FY, A_TQ, A_VX, A_VY, A_W
   } rbi_asel_type;

   // Multiplier operand B sources
   typedef enum logic [2:0] {
      B_IM, B_II, B_DT, B_JX, B_JY
   } rbi_bsel_type;

   // Saturating accumulate destinations
   typedef enum logic [2:0] {
      DST_VX, DST_VY, DST_W, DST_PX, DST_PY, DST_ANG
   } rbi_dst_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] scalar_amount;
      logic signed [31:0] arm_x;
      logic signed [31:0] arm_y;
   } rbi_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] angle;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] spin_rate;
   } rbi_rsp_type;

   typedef struct packed {
      logic         capture;    // latch the request beat
      logic         mul_en;     // product <= A * B
      rbi_asel_type a_sel;
      rbi_bsel_type b_sel;
      logic         save_en;    // keep the previous product
      logic         rnd_en;     // temp <= rounded product
      logic         rnd_cross;  // round (kept - product) instead
      logic         acc_en;     // destination += temp, saturated
      rbi_dst_type  acc_dst;
      logic         add_force;
      logic         add_torque;
      logic         clear_acc;
      logic         rsp_load;   // snapshot state into the result register
   } rbi_cmd_type;

endpackage

### hdl/rbi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_datapath
// Body state registers, one shared 32x32 multiplier with product register,
// a rounding stage and one saturating accumulator, driven by step commands.
// ----------------------------------------------------------------------------
module rbi_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rbi_pkg::rbi_cmd_type            cmd,
   input  rbi_pkg::rbi_req_type            req_data,
   input  logic [rbi_pkg::CFG_W-1:0]       inv_mass,
   input  logic [rbi_pkg::CFG_W-1:0]       inv_inertia,
   input  logic [rbi_pkg::CFG_W-1:0]       time_step,
   output rbi_pkg::rbi_rsp_type            rsp_data
);

   // Saturate a 50-bit value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] res;
      if (v[49:31] == {19{v[49]}}) begin
         res = v[31:0];
      end else if (v[49]) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'sh7FFF_FFFF;
      end
      return res;
   endfunction

   // Round half up from Q32.32 to Q16.16, then saturate
   function automatic logic signed [31:0] rescale(input logic signed [65:0] x);
      logic signed [65:0] q;
      q = x + 66'sd32768;
      return sat32($signed(q[65:16]));
   endfunction

   // Saturating 32-bit add
   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [32:0] s;
      logic signed [31:0] res;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         res = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         res = s[31:0];
      end
      return res;
   endfunction

   rbi_pkg::rbi_req_type item_ff, item_in;
   rbi_pkg::rbi_rsp_type rsp_ff, rsp_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in, ang_ff, ang_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, w_ff, w_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in, tq_ff, tq_in;
   logic signed [63:0] p_ff, p_in, c_ff, c_in;
   logic signed [31:0] t_ff, t_in;

   logic signed [31:0] a_val, b_val;
   logic signed [63:0] prod;
   logic signed [65:0] rnd_src;
   logic signed [31:0] acc_cur, acc_sum;

   // Select multiplier operands
   always_comb begin
      case (cmd.a_sel)
         rbi_pkg::A_JX: a_val = item_ff.vec_x;
         rbi_pkg::A_JY: a_val = item_ff.vec_y;
         rbi_pkg::A_S:  a_val = item_ff.scalar_amount;
         rbi_pkg::A_RX: a_val = item_ff.arm_x;
         rbi_pkg::A_RY: a_val = item_ff.arm_y;
         rbi_pkg::A_T:  a_val = t_ff;
         rbi_pkg::A_FX: a_val = fx_ff;
         rbi_pkg::A_FY: a_val = fy_ff;
         rbi_pkg::A_TQ: a_val = tq_ff;
         rbi_pkg::A_VX: a_val = vx_ff;
         rbi_pkg::A_VY: a_val = vy_ff;
         rbi_pkg::A_W:  a_val = w_ff;
         default:       a_val = '0;
      endcase
      case (cmd.b_sel)
         rbi_pkg::B_IM: b_val = $signed({1'b0, inv_mass});
         rbi_pkg::B_II: b_val = $signed({1'b0, inv_inertia});
         rbi_pkg::B_DT: b_val = $signed({1'b0, time_step});
         rbi_pkg::B_JX: b_val = item_ff.vec_x;
         rbi_pkg::B_JY: b_val = item_ff.vec_y;
         default:       b_val = '0;
      endcase
   end

   // Exact signed product, sign-extended in the 64-bit context
   assign prod = a_val * b_val;

   // Rounding source: plain product or the lever-arm cross difference
   assign rnd_src = cmd.rnd_cross
      ? ({{2{c_ff[63]}}, c_ff} - {{2{p_ff[63]}}, p_ff})
      : {{2{p_ff[63]}}, p_ff};

   // Pick the accumulate destination and add the rounded temp
   always_comb begin
      case (cmd.acc_dst)
         rbi_pkg::DST_VX:  acc_cur = vx_ff;
         rbi_pkg::DST_VY:  acc_cur = vy_ff;
         rbi_pkg::DST_W:   acc_cur = w_ff;
         rbi_pkg::DST_PX:  acc_cur = px_ff;
         rbi_pkg::DST_PY:  acc_cur = py_ff;
         rbi_pkg::DST_ANG: acc_cur = ang_ff;
         default:          acc_cur = '0;
      endcase
   end

   assign acc_sum = qadd(acc_cur, t_ff);

   // Next values of the datapath registers
   always_comb begin
      item_in = cmd.capture ? req_data : item_ff;
      p_in    = cmd.mul_en ? prod : p_ff;
      c_in    = cmd.save_en ? p_ff : c_ff;
      t_in    = cmd.rnd_en ? rescale(rnd_src) : t_ff;

      px_in  = px_ff;
      py_in  = py_ff;
      ang_in = ang_ff;
      vx_in  = vx_ff;
      vy_in  = vy_ff;
      w_in   = w_ff;
      fx_in  = fx_ff;
      fy_in  = fy_ff;
      tq_in  = tq_ff;

      if (cmd.add_force) begin
         fx_in = qadd(fx_ff, item_ff.vec_x);
         fy_in = qadd(fy_ff, item_ff.vec_y);
      end
      if (cmd.add_torque) begin
         tq_in = qadd(tq_ff, item_ff.scalar_amount);
      end
      if (cmd.clear_acc) begin
         fx_in = '0;
         fy_in = '0;
         tq_in = '0;
      end
      if (cmd.acc_en) begin
         case (cmd.acc_dst)
            rbi_pkg::DST_VX:  vx_in  = acc_sum;
            rbi_pkg::DST_VY:  vy_in  = acc_sum;
            rbi_pkg::DST_W:   w_in   = acc_sum;
            rbi_pkg::DST_PX:  px_in  = acc_sum;
            rbi_pkg::DST_PY:  py_in  = acc_sum;
            rbi_pkg::DST_ANG: ang_in = acc_sum;
            default: ;
         endcase
      end

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.pos_x     = px_ff;
         rsp_in.pos_y     = py_ff;
         rsp_in.angle     = ang_ff;
         rsp_in.vel_x     = vx_ff;
         rsp_in.vel_y     = vy_ff;
         rsp_in.spin_rate = w_ff;
      end
   end

   // Hold body state; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff  <= '0;
         py_ff  <= '0;
         ang_ff <= '0;
         vx_ff  <= '0;
         vy_ff  <= '0;
         w_ff   <= '0;
         fx_ff  <= '0;
         fy_ff  <= '0;
         tq_ff  <= '0;
      end else begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         ang_ff <= ang_in;
         vx_ff  <= vx_in;
         vy_ff  <= vy_in;
         w_ff   <= w_in;
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         tq_ff  <= tq_in;
      end
   end

   // Advance payload and working registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      p_ff    <= p_in;
      c_ff    <= c_in;
      t_ff    <= t_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

### hdl/rbi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_ctrl
// Sequencer: accepts a request beat, steps through the micro-program of its
// operation and the lock flags, then hands the body state to the result beat.
// ----------------------------------------------------------------------------
module rbi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_op,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 movement_locked,
   input  logic                 rotation_locked,
   output rbi_pkg::rbi_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WRITE
   } ctrl_state_type;

   ctrl_state_type               state_ff, state_in;
   logic [rbi_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [2:0]                   op_ff, op_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         last;
   logic                         slot_free;
   rbi_pkg::rbi_cmd_type         prog;

   // Micro-program: one command per step of the current operation
   always_comb begin
      prog = '0;
      last = 1'b0;
      case (op_ff)
         rbi_pkg::OP_ADD_FORCE: begin
            prog.add_force = 1'b1;
            last = 1'b1;
         end
         rbi_pkg::OP_ADD_TORQUE: begin
            prog.add_torque = 1'b1;
            last = 1'b1;
         end
         rbi_pkg::OP_LIN_IMPULSE: begin
            if (movement_locked) begin
               last = 1'b1;
            end else begin
               case (step_ff)
                  4'd0: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_JX; prog.b_sel = rbi_pkg::B_IM;
                  end
                  4'd1: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_JY; prog.b_sel = rbi_pkg::B_IM;
                     prog.rnd_en = 1'b1;
                  end
                  4'd2: begin
                     prog.rnd_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VX;
                  end
                  default: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VY;
                     last = 1'b1;
                  end
               endcase
            end
         end
         rbi_pkg::OP_ANG_IMPULSE: begin
            if (rotation_locked) begin
               last = 1'b1;
            end else begin
               case (step_ff)
                  4'd0: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_S; prog.b_sel = rbi_pkg::B_II;
                  end
                  4'd1: prog.rnd_en = 1'b1;
                  default: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_W;
                     last = 1'b1;
                  end
               endcase
            end
         end
         rbi_pkg::OP_POINT_IMPULSE: begin
            if (movement_locked || rotation_locked) begin
               last = 1'b1;
            end else begin
               case (step_ff)
                  4'd0: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_JX; prog.b_sel = rbi_pkg::B_IM;
                  end
                  4'd1: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_JY; prog.b_sel = rbi_pkg::B_IM;
                     prog.rnd_en = 1'b1;
                  end
                  4'd2: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_RX; prog.b_sel = rbi_pkg::B_JY;
                     prog.rnd_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VX;
                  end
                  4'd3: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_RY; prog.b_sel = rbi_pkg::B_JX;
                     prog.save_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VY;
                  end
                  4'd4: begin
                     prog.rnd_en = 1'b1; prog.rnd_cross = 1'b1;
                  end
                  4'd5: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_T; prog.b_sel = rbi_pkg::B_II;
                  end
                  4'd6: prog.rnd_en = 1'b1;
                  default: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_W;
                     last = 1'b1;
                  end
               endcase
            end
         end
         rbi_pkg::OP_INTEG_FORCE: begin
            if (movement_locked) begin
               last = 1'b1;
            end else begin
               case (step_ff)
                  4'd0: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_FX; prog.b_sel = rbi_pkg::B_IM;
                  end
                  4'd1: prog.rnd_en = 1'b1;
                  4'd2: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_T; prog.b_sel = rbi_pkg::B_DT;
                  end
                  4'd3: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_FY; prog.b_sel = rbi_pkg::B_IM;
                     prog.rnd_en = 1'b1;
                  end
                  4'd4: begin
                     prog.rnd_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VX;
                  end
                  4'd5: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_T; prog.b_sel = rbi_pkg::B_DT;
                  end
                  4'd6: prog.rnd_en = 1'b1;
                  4'd7: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_VY;
                     last = rotation_locked;
                  end
                  4'd8: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_TQ; prog.b_sel = rbi_pkg::B_II;
                  end
                  4'd9: prog.rnd_en = 1'b1;
                  4'd10: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_T; prog.b_sel = rbi_pkg::B_DT;
                  end
                  4'd11: prog.rnd_en = 1'b1;
                  default: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_W;
                     prog.clear_acc = 1'b1;
                     last = 1'b1;
                  end
               endcase
            end
         end
         rbi_pkg::OP_INTEG_VEL: begin
            if (movement_locked) begin
               last = 1'b1;
            end else begin
               case (step_ff)
                  4'd0: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_VX; prog.b_sel = rbi_pkg::B_DT;
                  end
                  4'd1: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_VY; prog.b_sel = rbi_pkg::B_DT;
                     prog.rnd_en = 1'b1;
                  end
                  4'd2: begin
                     prog.mul_en = 1'b1; prog.a_sel = rbi_pkg::A_W; prog.b_sel = rbi_pkg::B_DT;
                     prog.rnd_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_PX;
                  end
                  4'd3: begin
                     prog.rnd_en = 1'b1;
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_PY;
                     last = rotation_locked;
                  end
                  default: begin
                     prog.acc_en = 1'b1; prog.acc_dst = rbi_pkg::DST_ANG;
                     last = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

   // Result register may take a new snapshot when empty or being drained
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state, step and command
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_op;
               step_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd = prog;
            if (last) begin
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/rigid_body_2d_integrator.sv
`timescale 1ns / 1ps
// Each request beat runs the micro-program of its operation, whose step count
// is 1 for add force, add torque, the unused code and every locked case;
// 4 linear impulse, 3 angular impulse, 8 point impulse, 13 (8 with rotation
// locked) integrate forces, 5 (4) integrate velocities. A new request beat is
// taken only after the last result is loaded, which waits while a stalled result is held.
// Reset (synchronous): body state cleared, registers back to defaults, idle.
// ----------------------------------------------------------------------------
// rigid_body_2d_integrator
// Top level of the 2D rigid body integrator: register file on the APB-style
// port, sequencer and datapath, result beat register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rigid_body_2d_integrator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rbi_pkg::rbi_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rbi_pkg::rbi_rsp_type              rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [rbi_pkg::CFG_W-1:0] inv_mass_ff, inv_mass_in;
   logic [rbi_pkg::CFG_W-1:0] inv_inertia_ff, inv_inertia_in;
   logic [rbi_pkg::CFG_W-1:0] time_step_ff, time_step_in;
   logic                      move_lock_ff, move_lock_in;
   logic                      rot_lock_ff, rot_lock_in;
   logic                      csr_wr;
   logic [2:0]                csr_idx;
   rbi_pkg::rbi_cmd_type      cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   // Decode register writes
   always_comb begin
      inv_mass_in    = inv_mass_ff;
      inv_inertia_in = inv_inertia_ff;
      time_step_in   = time_step_ff;
      move_lock_in   = move_lock_ff;
      rot_lock_in    = rot_lock_ff;
      if (csr_wr) begin
         case (csr_idx)
            rbi_pkg::CSR_INV_MASS:    inv_mass_in    = csr_pwdata[rbi_pkg::CFG_W-1:0];
            rbi_pkg::CSR_INV_INERTIA: inv_inertia_in = csr_pwdata[rbi_pkg::CFG_W-1:0];
            rbi_pkg::CSR_TIME_STEP:   time_step_in   = csr_pwdata[rbi_pkg::CFG_W-1:0];
            rbi_pkg::CSR_MOVE_LOCK:   move_lock_in   = csr_pwdata[0];
            rbi_pkg::CSR_ROT_LOCK:    rot_lock_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff    <= rbi_pkg::INV_MASS_RESET;
         inv_inertia_ff <= rbi_pkg::INV_INERTIA_RESET;
         time_step_ff   <= rbi_pkg::TIME_STEP_RESET;
         move_lock_ff   <= 1'b0;
         rot_lock_ff    <= 1'b0;
      end else begin
         inv_mass_ff    <= inv_mass_in;
         inv_inertia_ff <= inv_inertia_in;
         time_step_ff   <= time_step_in;
         move_lock_ff   <= move_lock_in;
         rot_lock_ff    <= rot_lock_in;
      end
   end

   // Read back registers
   always_comb begin
      case (csr_idx)
         rbi_pkg::CSR_INV_MASS:    csr_prdata = {1'b0, inv_mass_ff};
         rbi_pkg::CSR_INV_INERTIA: csr_prdata = {1'b0, inv_inertia_ff};
         rbi_pkg::CSR_TIME_STEP:   csr_prdata = {1'b0, time_step_ff};
         rbi_pkg::CSR_MOVE_LOCK:   csr_prdata = {31'd0, move_lock_ff};
         rbi_pkg::CSR_ROT_LOCK:    csr_prdata = {31'd0, rot_lock_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   rbi_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_op          (req_data.op),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .movement_locked (move_lock_ff),
      .rotation_locked (rot_lock_ff),
      .cmd             (cmd)
   );

   rbi_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .inv_mass    (inv_mass_ff),
      .inv_inertia (inv_inertia_ff),
      .time_step   (time_step_ff),
      .rsp_data    (rsp_data)
   );

   // Never overwrite a result beat that is still stalled
   `RBI_ASSERT_IMPLIES(a_no_rsp_overwrite, clock, reset, cmd.rsp_load, !(rsp_valid && rsp_stall), "result overwritten while stalled")

   // An accepted beat keeps the input stalled while it is worked on
   `RBI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not stalled after accept")

   // Datapath updates only happen while an item is in flight
   `RBI_ASSERT_IMPLIES(a_work_while_busy, clock, reset, cmd.mul_en || cmd.acc_en || cmd.add_force || cmd.add_torque, req_stall, "datapath active while idle")

   // Linear state never moves while movement is locked
   `RBI_ASSERT_IMPLIES(a_move_lock, clock, reset, cmd.acc_en && (cmd.acc_dst == rbi_pkg::DST_VX || cmd.acc_dst == rbi_pkg::DST_VY || cmd.acc_dst == rbi_pkg::DST_PX || cmd.acc_dst == rbi_pkg::DST_PY), !move_lock_ff, "linear update while locked")

endmodule

### tb/rigid_body_2d_integrator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_2d_integrator_test
// Self-checking bench for the 2D rigid body integrator. A scoreboard keeps its
// own copy of the body state and the registers, predicts the state returned
// for every accepted request beat and compares each result beat field by
// field. Directed beats cover the field extremes, every operation and the
// lock cases; random phases then run under several register settings while
// the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module rigid_body_2d_integrator_test;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
   localparam logic [2:0]         OP_UNUSED = 3'd7;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic [31:0]        CFG_MAX = 32'h7FFF_FFFF;
   localparam int                 PHASE_COUNT = 8;
   localparam int                 BEATS_PER_PHASE = 190;

   // Scoreboard: body state predictor and queue of expected state beats
   class body_scoreboard;
      logic [30:0]          inv_mass;
      logic [30:0]          inv_inertia;
      logic [30:0]          time_step;
      bit                   move_lock;
      bit                   rot_lock;
      logic signed [31:0]   pos[2];
      logic signed [31:0]   vel[2];
      logic signed [31:0]   ang;
      logic signed [31:0]   spin;
      logic signed [31:0]   force_acc[2];
      logic signed [31:0]   torque_acc;
      rbi_pkg::rbi_rsp_type body_state_q[$];
      int                   errors;

      function new();
         inv_mass    = rbi_pkg::INV_MASS_RESET;
         inv_inertia = rbi_pkg::INV_INERTIA_RESET;
         time_step   = rbi_pkg::TIME_STEP_RESET;
         move_lock   = 1'b0;
         rot_lock    = 1'b0;
         pos         = '{0, 0};
         vel         = '{0, 0};
         force_acc   = '{0, 0};
         ang         = '0;
         spin        = '0;
         torque_acc  = '0;
         errors      = 0;
      endfunction

      function logic signed [31:0] clamp32(logic signed [65:0] v);
         if (v > SAT_HI) return Q_MAX;
         if (v < SAT_LO) return Q_MIN;
         return v[31:0];
      endfunction

      // Round half up from Q32.32 to Q16.16, then saturate
      function logic signed [31:0] round_q(logic signed [65:0] p);
         logic signed [65:0] q;
         q = p + 66'sd32768;
         return clamp32(q >>> 16);
      endfunction

      function logic signed [31:0] qmul(logic signed [65:0] a, logic signed [65:0] b);
         return round_q(a * b);
      endfunction

      function logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
         logic signed [65:0] s;
         s = a;
         s = s + b;
         return clamp32(s);
      endfunction

      function void apply_setting(rbi_pkg::rbi_csr_type idx, logic [31:0] value);
         case (idx)
            rbi_pkg::CSR_INV_MASS:    inv_mass    = value[30:0];
            rbi_pkg::CSR_INV_INERTIA: inv_inertia = value[30:0];
            rbi_pkg::CSR_TIME_STEP:   time_step   = value[30:0];
            rbi_pkg::CSR_MOVE_LOCK:   move_lock   = value[0];
            rbi_pkg::CSR_ROT_LOCK:    rot_lock    = value[0];
            default: ;
         endcase
      endfunction

      // Advance the body by one request beat and queue the resulting state
      function void note_request(rbi_pkg::rbi_req_type r);
         logic signed [65:0]   im, ii, dt, jx, jy, rx, ry;
         logic signed [31:0]   lever, accel;
         rbi_pkg::rbi_rsp_type st;
         im = $signed({1'b0, inv_mass});
         ii = $signed({1'b0, inv_inertia});
         dt = $signed({1'b0, time_step});
         jx = $signed(r.vec_x);
         jy = $signed(r.vec_y);
         rx = $signed(r.arm_x);
         ry = $signed(r.arm_y);
         case (r.op)
            rbi_pkg::OP_ADD_FORCE: begin
               force_acc[0] = qadd(force_acc[0], r.vec_x);
               force_acc[1] = qadd(force_acc[1], r.vec_y);
            end
            rbi_pkg::OP_ADD_TORQUE: begin
               torque_acc = qadd(torque_acc, r.scalar_amount);
            end
            rbi_pkg::OP_LIN_IMPULSE: begin
               if (!move_lock) begin
                  vel[0] = qadd(vel[0], qmul(jx, im));
                  vel[1] = qadd(vel[1], qmul(jy, im));
               end
            end
            rbi_pkg::OP_ANG_IMPULSE: begin
               if (!rot_lock) spin = qadd(spin, qmul($signed(r.scalar_amount), ii));
            end
            rbi_pkg::OP_POINT_IMPULSE: begin
               if (!move_lock && !rot_lock) begin
                  vel[0] = qadd(vel[0], qmul(jx, im));
                  vel[1] = qadd(vel[1], qmul(jy, im));
                  lever  = round_q(rx * jy - ry * jx);
                  spin   = qadd(spin, qmul(lever, ii));
               end
            end
            rbi_pkg::OP_INTEG_FORCE: begin
               // Locked rotation leaves both accumulators uncleared
               if (!move_lock) begin
                  for (int i = 0; i < 2; i++) begin
                     accel  = qmul(force_acc[i], im);
                     vel[i] = qadd(vel[i], qmul(accel, dt));
                  end
                  if (!rot_lock) begin
                     spin       = qadd(spin, qmul(qmul(torque_acc, ii), dt));
                     force_acc  = '{0, 0};
                     torque_acc = '0;
                  end
               end
            end
            rbi_pkg::OP_INTEG_VEL: begin
               if (!move_lock) begin
                  pos[0] = qadd(pos[0], qmul(vel[0], dt));
                  pos[1] = qadd(pos[1], qmul(vel[1], dt));
                  if (!rot_lock) ang = qadd(ang, qmul(spin, dt));
               end
            end
            default: ;
         endcase
         st.pos_x     = pos[0];
         st.pos_y     = pos[1];
         st.angle     = ang;
         st.vel_x     = vel[0];
         st.vel_y     = vel[1];
         st.spin_rate = spin;
         body_state_q.push_back(st);
      endfunction

      function void check_field(string name, logic signed [31:0] exp_v,
                                logic signed [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(rbi_pkg::rbi_rsp_type act);
         rbi_pkg::rbi_rsp_type exp_s;
         if (body_state_q.size() == 0) begin
            $error("result beat arrived with no state expected");
            errors++;
            return;
         end
         exp_s = body_state_q.pop_front();
         check_field("pos_x", exp_s.pos_x, act.pos_x);
         check_field("pos_y", exp_s.pos_y, act.pos_y);
         check_field("angle", exp_s.angle, act.angle);
         check_field("vel_x", exp_s.vel_x, act.vel_x);
         check_field("vel_y", exp_s.vel_y, act.vel_y);
         check_field("spin_rate", exp_s.spin_rate, act.spin_rate);
      endfunction

      function int pending();
         return body_state_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   rbi_pkg::rbi_req_type           req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   rbi_pkg::rbi_rsp_type           rsp_data;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [rbi_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rbi_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rbi_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   body_scoreboard sb = new();
   int             burst_left = 0;
   int             stall_mode = 0;
   int             stall_run = 0;

   rigid_body_2d_integrator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watch both channels and hand accepted beats to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // Stall the result channel in runs: free, random, mostly stalled, periodic
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_run  <= $urandom_range(10, 80);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= stall_run[2];
      endcase
   end

   function automatic rbi_pkg::rbi_req_type make_beat(logic [2:0] op, logic [31:0] vx,
                                                      logic [31:0] vy, logic [31:0] s,
                                                      logic [31:0] ax, logic [31:0] ay);
      rbi_pkg::rbi_req_type b;
      b.op            = op;
      b.vec_x         = vx;
      b.vec_y         = vy;
      b.scalar_amount = s;
      b.arm_x         = ax;
      b.arm_y         = ay;
      return b;
   endfunction

   // Mostly modest magnitudes so the state does not pin at the rails
   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Send one beat; open a new burst, often after a gap, when one runs out
   task automatic push_beat(input rbi_pkg::rbi_req_type beat);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 10));
      end
      burst_left--;
      @(negedge clock);
      req_data  = beat;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every expected state beat is back
   task automatic drain();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input rbi_pkg::rbi_csr_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.apply_setting(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_body(input logic [31:0] im, input logic [31:0] ii,
                           input logic [31:0] dt, input logic [31:0] ml,
                           input logic [31:0] rl);
      csr_write(rbi_pkg::CSR_INV_MASS, im);
      csr_write(rbi_pkg::CSR_INV_INERTIA, ii);
      csr_write(rbi_pkg::CSR_TIME_STEP, dt);
      csr_write(rbi_pkg::CSR_MOVE_LOCK, ml);
      csr_write(rbi_pkg::CSR_ROT_LOCK, rl);
   endtask

   initial begin
      logic [2:0]  op;
      logic [31:0] gain;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Plain operations on the reset settings
      push_beat(make_beat(rbi_pkg::OP_ADD_FORCE, 32'h0003_0000, 32'hFFFE_0000, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_ADD_TORQUE, 0, 0, 32'h0001_8000, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_LIN_IMPULSE, 32'h0000_8000, 32'hFFFF_4000, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_ANG_IMPULSE, 0, 0, 32'hFFFF_0001, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_POINT_IMPULSE, 32'h0001_0000, 32'h0002_0000, 0,
                          32'h0000_4000, 32'hFFFF_C000));
      push_beat(make_beat(rbi_pkg::OP_INTEG_FORCE, 0, 0, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_INTEG_VEL, 0, 0, 0, 0, 0));

      // Movement locked: impulses and both integrations do nothing
      drain();
      csr_write(rbi_pkg::CSR_MOVE_LOCK, 32'd1);
      push_beat(make_beat(rbi_pkg::OP_ADD_FORCE, 32'h0005_0000, 32'h0001_0000, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_LIN_IMPULSE, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_POINT_IMPULSE, 32'h0001_0000, 32'h0001_0000, 0,
                          32'h0001_0000, 32'h0001_0000));
      push_beat(make_beat(rbi_pkg::OP_INTEG_FORCE, 0, 0, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_INTEG_VEL, 0, 0, 0, 0, 0));

      // Rotation locked: no angular change, accumulators survive integration
      drain();
      csr_write(rbi_pkg::CSR_MOVE_LOCK, 32'd0);
      csr_write(rbi_pkg::CSR_ROT_LOCK, 32'd1);
      push_beat(make_beat(rbi_pkg::OP_ADD_TORQUE, 0, 0, 32'h0002_0000, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_ANG_IMPULSE, 0, 0, 32'h0004_0000, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_POINT_IMPULSE, 32'h0001_0000, 32'h0001_0000, 0,
                          32'h0001_0000, 32'h0002_0000));
      push_beat(make_beat(rbi_pkg::OP_INTEG_FORCE, 0, 0, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_INTEG_VEL, 0, 0, 0, 0, 0));
      drain();
      csr_write(rbi_pkg::CSR_ROT_LOCK, 32'd0);
      push_beat(make_beat(rbi_pkg::OP_INTEG_FORCE, 0, 0, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_INTEG_VEL, 0, 0, 0, 0, 0));

      // Field extremes: saturating sums, extreme cross product, unused code
      push_beat(make_beat(rbi_pkg::OP_ADD_FORCE, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
      push_beat(make_beat(rbi_pkg::OP_ADD_FORCE, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN));
      push_beat(make_beat(rbi_pkg::OP_ADD_TORQUE, 0, 0, Q_MIN, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_LIN_IMPULSE, Q_MIN, Q_MAX, 0, 0, 0));
      push_beat(make_beat(rbi_pkg::OP_POINT_IMPULSE, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
      push_beat(make_beat(OP_UNUSED, '1, '1, '1, '1, '1));
      drain();

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         gain = 32'h0004_0000;
         case (phase)
            0: set_body(rbi_pkg::INV_MASS_RESET, rbi_pkg::INV_INERTIA_RESET,
                        rbi_pkg::TIME_STEP_RESET, 0, 0);
            1: set_body(CFG_MAX, CFG_MAX, CFG_MAX, 0, 0);
            2: set_body(0, 0, 0, 0, 0);
            3: set_body($urandom_range(0, gain), $urandom_range(0, gain),
                        $urandom_range(0, gain), 1, 0);
            4: set_body($urandom_range(0, gain), $urandom_range(0, gain),
                        $urandom_range(0, gain), 0, 1);
            5: set_body($urandom_range(0, gain), $urandom_range(0, gain),
                        $urandom_range(0, gain), 1, 1);
            6: set_body($urandom, $urandom, $urandom, $urandom, $urandom);
            default: set_body($urandom_range(0, gain), $urandom_range(0, gain),
                              $urandom_range(0, 32'h0000_1000), 0, 0);
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if ($urandom_range(0, 24) == 0) op = OP_UNUSED;
            else op = $urandom_range(rbi_pkg::OP_ADD_FORCE, rbi_pkg::OP_INTEG_VEL);
            push_beat(make_beat(op, rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Bound the run well above the slowest legal schedule
   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/rbi_pkg.sv
hdl/rbi_datapath.sv
hdl/rbi_ctrl.sv
hdl/rigid_body_2d_integrator.sv
tb/rigid_body_2d_integrator_test.sv
